// File: rtl/accel_tilt_pitch_roll_assert.svh
// Assertion macros for the tilt pipeline. Both expect clk and rst in scope.
`ifndef ACCEL_TILT_PITCH_ROLL_ASSERT_SVH
`define ACCEL_TILT_PITCH_ROLL_ASSERT_SVH

// cons must hold in the same cycle as ante
`define ATP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tilt pipeline check failed");

// cons must hold in the cycle after ante
`define ATP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tilt pipeline check failed");

`endif

// File: rtl/atp_pkg.sv
package atp_pkg;

  localparam int IN_W         = 8;
  localparam int SQ_W         = 16;
  localparam int ROOT_W       = 32;
  localparam int REM_W        = 36;
  localparam int SQRT_STEPS   = 32;
  localparam int FRAC_BITS    = 24;
  localparam int CORDIC_STEPS = 28;
  localparam int XY_W         = 36;
  localparam int ACC_W        = 34;
  localparam int TAB_W        = 30;
  localparam int PROD_W       = 50;
  localparam int RND_SH       = 32;
  localparam int ANG_W        = 15;
  localparam int ANG_MAX      = 9000;
  localparam int DEG_SCALE    = 36000;

  localparam int SQRT_PER_STAGE   = 4;
  localparam int CORDIC_PER_STAGE = 4;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [TAB_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5
  };

  typedef struct packed {
    logic [SQ_W-1:0]        s;
    logic signed [IN_W-1:0] n;
    logic                   zero;
  } sq_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
  } cordic_st_t;

  // One digit of the root of s * 2^48, step k counted from the top pair.
  function automatic sqrt_st_t sqrt_step(sqrt_st_t st, logic [SQ_W-1:0] s, int k);
    logic [2*ROOT_W-1:0] rad;
    logic [1:0]          pair;
    logic [REM_W-1:0]    rem2;
    logic [REM_W-1:0]    trial;
    sqrt_st_t            r;
    rad   = {s, {(2*ROOT_W-SQ_W){1'b0}}};
    pair  = rad[2*ROOT_W-1-2*k -: 2];
    rem2  = {st.rem[REM_W-3:0], pair};
    trial = REM_W'({st.root, 2'b01});
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {st.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {st.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // One vectoring rotation, floor shifts.
  function automatic cordic_st_t cordic_step(cordic_st_t st, int i);
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    logic signed [ACC_W-1:0] ang;
    cordic_st_t              r;
    x   = st.x;
    y   = st.y;
    dx  = y >>> i;
    dy  = x >>> i;
    ang = $signed(ACC_W'(ATAN_TURN[i]));
    if (!y[XY_W-1]) begin
      r.x   = x + dx;
      r.y   = y - dy;
      r.acc = st.acc + ang;
    end else begin
      r.x   = x - dx;
      r.y   = y + dy;
      r.acc = st.acc - ang;
    end
    return r;
  endfunction

endpackage

// File: rtl/atp_front.sv
module atp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [atp_pkg::IN_W-1:0] accel_x,
  input  logic signed [atp_pkg::IN_W-1:0] accel_y,
  input  logic signed [atp_pkg::IN_W-1:0] accel_z,
  output logic                          out_valid,
  output atp_pkg::sq_t                  pitch_sq,
  output atp_pkg::sq_t                  roll_sq
);
  import atp_pkg::*;

  logic [SQ_W-1:0] xx, yy, zz;
  sq_t             pitch_next, roll_next;

  always_comb begin
    xx = SQ_W'(SQ_W'(accel_x) * SQ_W'(accel_x));
    yy = SQ_W'(SQ_W'(accel_y) * SQ_W'(accel_y));
    zz = SQ_W'(SQ_W'(accel_z) * SQ_W'(accel_z));
    pitch_next.s    = xx + zz;
    pitch_next.n    = accel_y;
    pitch_next.zero = (pitch_next.s == '0) && (accel_y == '0);
    roll_next.s     = yy + zz;
    roll_next.n     = accel_x;
    roll_next.zero  = (roll_next.s == '0) && (accel_x == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_sq <= pitch_next;
      roll_sq  <= roll_next;
    end
  end

endmodule

// File: rtl/atp_isqrt.sv
module atp_isqrt #(
  parameter int PER_STAGE = atp_pkg::SQRT_PER_STAGE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  atp_pkg::sq_t                    in_sq,
  output logic                            out_valid,
  output logic [atp_pkg::ROOT_W-1:0]      root,
  output logic signed [atp_pkg::IN_W-1:0] n,
  output logic                            zero
);
  import atp_pkg::*;

  localparam int NS = (SQRT_STEPS + PER_STAGE - 1) / PER_STAGE;

  sqrt_st_t st_q  [NS];
  sq_t      sq_q  [NS];
  logic     vld_q [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    sqrt_st_t st_in, st_next;
    sq_t      sq_in;
    logic     vld_in;

    if (g == 0) begin : g_first
      assign st_in  = '0;
      assign sq_in  = in_sq;
      assign vld_in = in_valid;
    end else begin : g_rest
      assign st_in  = st_q[g-1];
      assign sq_in  = sq_q[g-1];
      assign vld_in = vld_q[g-1];
    end

    always_comb begin
      st_next = st_in;
      for (int j = 0; j < PER_STAGE; j++) begin
        if (g * PER_STAGE + j < SQRT_STEPS) begin
          st_next = sqrt_step(st_next, sq_in.s, g * PER_STAGE + j);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_q[g] <= st_next;
        sq_q[g] <= sq_in;
      end
    end
  end

  assign out_valid = vld_q[NS-1];
  assign root      = st_q[NS-1].root;
  assign n         = sq_q[NS-1].n;
  assign zero      = sq_q[NS-1].zero;

endmodule

// File: rtl/atp_cordic.sv
module atp_cordic #(
  parameter int PER_STAGE = atp_pkg::CORDIC_PER_STAGE
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [atp_pkg::ROOT_W-1:0]       root,
  input  logic signed [atp_pkg::IN_W-1:0]  n,
  input  logic                             in_zero,
  output logic                             out_valid,
  output logic signed [atp_pkg::ACC_W-1:0] acc,
  output logic                             out_zero
);
  import atp_pkg::*;

  localparam int NS = (CORDIC_STEPS + PER_STAGE - 1) / PER_STAGE;

  cordic_st_t st_q   [NS];
  logic       zero_q [NS];
  logic       vld_q  [NS];
  cordic_st_t st_init;

  always_comb begin
    st_init.x   = XY_W'(root);
    st_init.y   = $signed(XY_W'(n)) <<< FRAC_BITS;
    st_init.acc = '0;
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    cordic_st_t st_in, st_next;
    logic       zero_in, vld_in;

    if (g == 0) begin : g_first
      assign st_in   = st_init;
      assign zero_in = in_zero;
      assign vld_in  = in_valid;
    end else begin : g_rest
      assign st_in   = st_q[g-1];
      assign zero_in = zero_q[g-1];
      assign vld_in  = vld_q[g-1];
    end

    always_comb begin
      st_next = st_in;
      for (int j = 0; j < PER_STAGE; j++) begin
        if (g * PER_STAGE + j < CORDIC_STEPS) begin
          st_next = cordic_step(st_next, g * PER_STAGE + j);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_q[g]   <= st_next;
        zero_q[g] <= zero_in;
      end
    end
  end

  assign out_valid = vld_q[NS-1];
  assign acc       = st_q[NS-1].acc;
  assign out_zero  = zero_q[NS-1];

endmodule

// File: rtl/atp_scale.sv
module atp_scale (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [atp_pkg::ACC_W-1:0] acc,
  input  logic                             zero,
  output logic                             out_valid,
  output logic signed [atp_pkg::ANG_W-1:0] angle
);
  import atp_pkg::*;

  localparam logic signed [PROD_W-1:0] SCALE = PROD_W'(DEG_SCALE);
  localparam logic [PROD_W-1:0]        HALF  = PROD_W'(1) << (RND_SH - 1);

  logic signed [PROD_W-1:0] prod;
  logic                     vld_a;
  logic                     neg;
  logic [PROD_W-1:0]        mag, rnd;
  logic [PROD_W-RND_SH-1:0] hmag;
  logic [ANG_W-1:0]         ang_mag;
  logic signed [ANG_W-1:0]  angle_next;

  // round half away from zero, then clamp to +-90.00
  always_comb begin
    neg     = prod[PROD_W-1];
    mag     = neg ? PROD_W'(-prod) : PROD_W'(prod);
    rnd     = mag + HALF;
    hmag    = rnd[PROD_W-1:RND_SH];
    ang_mag = (hmag > (PROD_W-RND_SH)'(ANG_MAX)) ? ANG_W'(ANG_MAX) : hmag[ANG_W-1:0];
    angle_next = neg ? $signed(-ang_mag) : $signed(ang_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld_a     <= in_valid;
      out_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= zero ? '0 : PROD_W'(acc) * SCALE;
      angle <= angle_next;
    end
  end

endmodule

// File: rtl/accel_tilt_pitch_roll.sv
// Tilt from one three-axis accelerometer word: pitch = atan2(y, sqrt(x^2+z^2)) and
// roll = atan2(x, sqrt(y^2+z^2)), each in signed hundredths of a degree,
// rounded, -9000..9000, and 0 when numerator and root are both zero. The block
// takes one word per clock while in_stall is low and has one result per word;
// each word passes the front squares register, then the unrolled 32-digit
// square root and the 28-step CORDIC pipelines, then the scaling registers.
// The whole pipeline advances together: in_stall is high only while
// a finished result is held by out_stall.
`include "accel_tilt_pitch_roll_assert.svh"

module accel_tilt_pitch_roll #(
  parameter int SQRT_PER_STAGE   = atp_pkg::SQRT_PER_STAGE,
  parameter int CORDIC_PER_STAGE = atp_pkg::CORDIC_PER_STAGE
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [atp_pkg::IN_W-1:0]  accel_x,
  input  logic signed [atp_pkg::IN_W-1:0]  accel_y,
  input  logic signed [atp_pkg::IN_W-1:0]  accel_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [atp_pkg::ANG_W-1:0] pitch_angle,
  output logic signed [atp_pkg::ANG_W-1:0] roll_angle
);
  import atp_pkg::*;

  logic en;
  logic front_vld;
  sq_t  pitch_sq, roll_sq;

  logic                    p_sq_vld, r_sq_vld;
  logic [ROOT_W-1:0]       p_root, r_root;
  logic signed [IN_W-1:0]  p_n, r_n;
  logic                    p_zero, r_zero;

  logic                    p_cd_vld, r_cd_vld;
  logic signed [ACC_W-1:0] p_acc, r_acc;
  logic                    p_cd_zero, r_cd_zero;

  logic                    roll_vld;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  atp_front u_front (
    .clk, .rst, .en, .in_valid,
    .accel_x, .accel_y, .accel_z,
    .out_valid (front_vld),
    .pitch_sq, .roll_sq
  );

  atp_isqrt #(.PER_STAGE(SQRT_PER_STAGE)) u_isqrt_pitch (
    .clk, .rst, .en,
    .in_valid (front_vld), .in_sq (pitch_sq),
    .out_valid (p_sq_vld), .root (p_root), .n (p_n), .zero (p_zero)
  );

  atp_isqrt #(.PER_STAGE(SQRT_PER_STAGE)) u_isqrt_roll (
    .clk, .rst, .en,
    .in_valid (front_vld), .in_sq (roll_sq),
    .out_valid (r_sq_vld), .root (r_root), .n (r_n), .zero (r_zero)
  );

  atp_cordic #(.PER_STAGE(CORDIC_PER_STAGE)) u_cordic_pitch (
    .clk, .rst, .en,
    .in_valid (p_sq_vld), .root (p_root), .n (p_n), .in_zero (p_zero),
    .out_valid (p_cd_vld), .acc (p_acc), .out_zero (p_cd_zero)
  );

  atp_cordic #(.PER_STAGE(CORDIC_PER_STAGE)) u_cordic_roll (
    .clk, .rst, .en,
    .in_valid (r_sq_vld), .root (r_root), .n (r_n), .in_zero (r_zero),
    .out_valid (r_cd_vld), .acc (r_acc), .out_zero (r_cd_zero)
  );

  atp_scale u_scale_pitch (
    .clk, .rst, .en,
    .in_valid (p_cd_vld), .acc (p_acc), .zero (p_cd_zero),
    .out_valid (out_valid), .angle (pitch_angle)
  );

  atp_scale u_scale_roll (
    .clk, .rst, .en,
    .in_valid (r_cd_vld), .acc (r_acc), .zero (r_cd_zero),
    .out_valid (roll_vld), .angle (roll_angle)
  );

  // both lanes see the same enable, so their valid bits must stay in lockstep
  `ATP_ASSERT_NOW(a_lanes_aligned, 1'b1, roll_vld == out_valid)
  `ATP_ASSERT_NEXT(a_word_enters, in_valid && !in_stall, front_vld)
  `ATP_ASSERT_NOW(a_pitch_range, out_valid, (pitch_angle >= -15'sd9000) && (pitch_angle <= 15'sd9000))
  `ATP_ASSERT_NOW(a_roll_range, out_valid, (roll_angle >= -15'sd9000) && (roll_angle <= 15'sd9000))

endmodule

// File: verif/tilt_angle_checker.sv
`timescale 1ns / 100ps

module tilt_angle_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic signed [atp_pkg::IN_W-1:0]  accel_x,
  input  logic signed [atp_pkg::IN_W-1:0]  accel_y,
  input  logic signed [atp_pkg::IN_W-1:0]  accel_z,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [atp_pkg::ANG_W-1:0] pitch_angle,
  input  logic signed [atp_pkg::ANG_W-1:0] roll_angle,
  output int                               words_in,
  output int                               results_out,
  output int                               mismatches
);

  localparam int STEPS = 28;

  // atan(2^-i) in 2^-32 turn, rounded
  localparam longint TURN_ATAN [STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5
  };

  typedef struct packed {
    logic signed [atp_pkg::ANG_W-1:0] pitch;
    logic signed [atp_pkg::ANG_W-1:0] roll;
  } tilt_pair_t;

  tilt_pair_t tilt_q[$];
  tilt_pair_t want;
  int         bad;

  // atan2(num, sqrt(a^2 + b^2)) in hundredths of a degree
  function automatic logic signed [atp_pkg::ANG_W-1:0] tilt_hundredths(
    longint num, longint a, longint b);
    longint unsigned rad;
    longint unsigned root;
    longint unsigned probe;
    longint          xr;
    longint          yr;
    longint          acc;
    longint          dx;
    longint          dy;
    longint          prod;
    longint          h;
    rad   = longint'(a * a + b * b) << 48;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rad) probe = probe >> 2;
    while (probe != 0) begin
      if (rad >= root + probe) begin
        rad  = rad - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    xr  = longint'(root);
    yr  = num * 64'sd16777216;
    acc = 0;
    if (xr == 0 && yr == 0) return '0;
    for (int i = 0; i < STEPS; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (yr >= 0) begin
        xr  = xr + dx;
        yr  = yr - dy;
        acc = acc + TURN_ATAN[i];
      end else begin
        xr  = xr - dx;
        yr  = yr + dy;
        acc = acc - TURN_ATAN[i];
      end
    end
    // 36000 hundredths per turn, halves away from zero
    prod = acc * 36000;
    if (prod >= 0) h = (prod + 64'sd2147483648) >>> 32;
    else h = -((-prod + 64'sd2147483648) >>> 32);
    if (h > atp_pkg::ANG_MAX) h = atp_pkg::ANG_MAX;
    if (h < -atp_pkg::ANG_MAX) h = -atp_pkg::ANG_MAX;
    return atp_pkg::ANG_W'(h);
  endfunction

  function automatic tilt_pair_t predict_tilt(logic signed [7:0] x, logic signed [7:0] y,
                                              logic signed [7:0] z);
    tilt_pair_t t;
    t.pitch = tilt_hundredths(y, x, z);
    t.roll  = tilt_hundredths(x, y, z);
    return t;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      words_in    <= 0;
      results_out <= 0;
      mismatches  <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        tilt_q.push_back(predict_tilt(accel_x, accel_y, accel_z));
        words_in <= words_in + 1;
      end
      if (out_valid && !out_stall) begin
        bad = 0;
        if (tilt_q.size() == 0) begin
          $error("unexpected word: pitch_angle %0d roll_angle %0d", pitch_angle, roll_angle);
          bad = 1;
        end else begin
          want = tilt_q.pop_front();
          if (pitch_angle !== want.pitch) begin
            $error("pitch_angle: expected %0d, got %0d", want.pitch, pitch_angle);
            bad = bad + 1;
          end
          if (roll_angle !== want.roll) begin
            $error("roll_angle: expected %0d, got %0d", want.roll, roll_angle);
            bad = bad + 1;
          end
        end
        results_out <= results_out + 1;
        mismatches  <= mismatches + bad;
      end
    end
  end

endmodule

// File: verif/tb_accel_tilt_pitch_roll.sv
`timescale 1ns / 100ps

module tb_accel_tilt_pitch_roll;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic signed [atp_pkg::IN_W-1:0]  accel_x;
  logic signed [atp_pkg::IN_W-1:0]  accel_y;
  logic signed [atp_pkg::IN_W-1:0]  accel_z;
  logic                             out_valid;
  logic                             out_stall;
  logic signed [atp_pkg::ANG_W-1:0] pitch_angle;
  logic signed [atp_pkg::ANG_W-1:0] roll_angle;

  int   words_in;
  int   results_out;
  int   mismatches;
  logic quiet;
  logic squeeze;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  accel_tilt_pitch_roll u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .accel_z     (accel_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pitch_angle (pitch_angle),
    .roll_angle  (roll_angle)
  );

  tilt_angle_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .accel_z     (accel_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pitch_angle (pitch_angle),
    .roll_angle  (roll_angle),
    .words_in    (words_in),
    .results_out (results_out),
    .mismatches  (mismatches)
  );

  // offer one word, hold it until accepted
  task automatic send_word(logic signed [7:0] x, logic signed [7:0] y, logic signed [7:0] z);
    if (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x  <= x;
    accel_y  <= y;
    accel_z  <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [7:0] rand_axis();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 8'($urandom);
    if (pick < 85) return 8'(int'($urandom_range(8)) - 4);
    if (pick < 95) return 8'sd0;
    case ($urandom_range(3))
      0: return -8'sd128;
      1: return 8'sd127;
      2: return -8'sd1;
      default: return 8'sd1;
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off to back the pipeline up
  initial begin
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
      end
      out_stall <= !quiet && ($urandom_range(99) < 25);
    end
  end

  initial begin
    #4000000;
    $display("FAIL accel_tilt_pitch_roll");
    $finish;
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    accel_x  = '0;
    accel_y  = '0;
    accel_z  = '0;
    quiet    = 1'b0;
    squeeze  = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // zero vector: both angles zero
    send_word(8'sd0, 8'sd0, 8'sd0);
    // zero root with nonzero numerator, saturating at +/-90
    send_word(8'sd0, 8'sd127, 8'sd0);
    send_word(8'sd0, -8'sd128, 8'sd0);
    send_word(8'sd127, 8'sd0, 8'sd0);
    send_word(-8'sd128, 8'sd0, 8'sd0);
    send_word(8'sd0, 8'sd1, 8'sd0);
    send_word(-8'sd1, 8'sd0, 8'sd0);
    send_word(8'sd0, 8'sd0, 8'sd127);
    send_word(8'sd0, 8'sd0, -8'sd128);
    send_word(8'sd0, 8'sd0, 8'sd1);
    send_word(8'sd127, 8'sd127, 8'sd127);
    send_word(-8'sd128, -8'sd128, -8'sd128);
    send_word(-8'sd128, 8'sd127, 8'sd0);
    send_word(8'sd127, -8'sd128, -8'sd128);
    send_word(-8'sd128, -8'sd128, 8'sd0);
    send_word(8'sd1, 8'sd1, 8'sd1);
    send_word(-8'sd1, -8'sd1, -8'sd1);
    send_word(8'sd64, -8'sd64, 8'sd32);
    send_word(8'sd100, 8'sd0, -8'sd100);
    send_word(8'sd1, -8'sd128, 8'sd1);

    for (int k = 0; k < 600; k++) send_word(rand_axis(), rand_axis(), rand_axis());

    quiet <= 1'b1;
    for (int k = 0; k < 300; k++) send_word(rand_axis(), rand_axis(), rand_axis());

    // sender keeps offering while the output is held
    squeeze <= 1'b1;
    for (int k = 0; k < 200; k++) send_word(rand_axis(), rand_axis(), rand_axis());

    quiet <= 1'b0;
    for (int k = 0; k < 600; k++) send_word(rand_axis(), rand_axis(), rand_axis());

    in_valid <= 1'b0;
    @(posedge clk);
    wait (words_in == results_out);
    repeat (40) @(posedge clk);

    $display("Run covered %0d accel words and %0d tilt results checked:", words_in,
             results_out);
    $display("axis extremes, zero vectors, random samples, gap-free bursts, long hold-off.");
    if (mismatches == 0 && words_in == results_out) begin
      $display("PASS accel_tilt_pitch_roll");
    end else begin
      $display("FAIL accel_tilt_pitch_roll");
    end
    $finish;
  end

endmodule
